// ===== rtl/core/bslp_pkg.sv =====
// Shared types, constants and register codes for the button press detector.
`default_nettype none
package bslp_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int REG_W           = 16;
   localparam int CSR_IDX_W       = 8;

   localparam logic [REG_W-1:0] DEBOUNCE_RST = REG_W'(50);
   localparam logic [REG_W-1:0] HOLD_MIN_RST = REG_W'(150);
   localparam logic [REG_W-1:0] LONG_RST     = REG_W'(700);
   localparam logic [REG_W-1:0] LOCKOUT_RST  = REG_W'(2000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE = CSR_IDX_W'(0),
      REG_HOLD_MIN = CSR_IDX_W'(1),
      REG_LONG     = CSR_IDX_W'(2),
      REG_LOCKOUT  = CSR_IDX_W'(3)
   } bslp_reg_type;

   typedef struct packed {
      logic [REG_W-1:0] debounce_ticks;
      logic [REG_W-1:0] hold_min_ticks;
      logic [REG_W-1:0] long_press_ticks;
      logic [REG_W-1:0] boot_lockout_ticks;
   } bslp_cfg_type;

   typedef struct packed {
      logic raw_level;
      logic long_inhibit;
   } bslp_in_type;

   typedef struct packed {
      logic short_press;
      logic long_press;
   } bslp_out_type;

   typedef struct packed {
      logic press_armed;
      logic long_done;
   } bslp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/bslp_if.sv =====
// Valid/ready channel interfaces for request, response and register words.
`default_nettype none
interface bslp_req_if;
   logic valid;
   logic ready;
   logic raw_level;
   logic long_inhibit;
   modport source (output valid, output raw_level, output long_inhibit, input ready);
   modport sink   (input valid, input raw_level, input long_inhibit, output ready);
endinterface

interface bslp_rsp_if;
   logic valid;
   logic ready;
   logic short_press;
   logic long_press;
   modport source (output valid, output short_press, output long_press, input ready);
   modport sink   (input valid, input short_press, input long_press, output ready);
endinterface

interface bslp_csr_if import bslp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bslp_core.sv =====
// Debounce, lockout and press-timing state with its one-tick update.
`default_nettype none
module bslp_core import bslp_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire bslp_in_type   item,
   input  wire bslp_cfg_type  cfg,
   output bslp_out_type       result,
   output bslp_stat_type      stat
);

   localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

   logic                   last_raw_ff, last_raw_in;
   logic                   deb_level_ff, deb_level_in;
   logic [COUNT_WIDTH-1:0] quiet_ff, quiet_in;
   logic [COUNT_WIDTH-1:0] uptime_ff, uptime_in;
   logic                   armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0] held_ff, held_in;
   logic                   long_done_ff, long_done_in;

   always_comb begin
      logic [COUNT_WIDTH-1:0] held_inc;
      logic                   quiet_ok;
      logic                   short_p;
      logic                   long_p;

      short_p      = 1'b0;
      long_p       = 1'b0;
      last_raw_in  = last_raw_ff;
      deb_level_in = deb_level_ff;
      armed_in     = armed_ff;
      long_done_in = long_done_ff;

      // advance uptime and hold time, saturating
      uptime_in = (&uptime_ff) ? uptime_ff : uptime_ff + 1'b1;
      held_inc  = (armed_ff && !(&held_ff)) ? held_ff + 1'b1 : held_ff;
      held_in   = held_inc;

      if (item.raw_level != last_raw_ff) begin
         last_raw_in = item.raw_level;
         quiet_in    = '0;
      end else begin
         quiet_in = (&quiet_ff) ? quiet_ff : quiet_ff + 1'b1;
      end

      quiet_ok = CMP_W'(quiet_in) > CMP_W'(cfg.debounce_ticks);

      if (quiet_ok) begin
         if (item.raw_level != deb_level_ff) begin
            deb_level_in = item.raw_level;
            if (!item.raw_level) begin
               if (CMP_W'(uptime_in) > CMP_W'(cfg.boot_lockout_ticks)) begin
                  armed_in     = 1'b1;
                  held_in      = '0;
                  long_done_in = 1'b0;
               end
            end else if (armed_ff) begin
               short_p  = !long_done_ff &&
                          (CMP_W'(held_inc) >= CMP_W'(cfg.hold_min_ticks));
               armed_in = 1'b0;
               held_in  = '0;
            end
         end else if (!deb_level_ff && armed_ff && !long_done_ff && !item.long_inhibit &&
                      (CMP_W'(held_inc) >= CMP_W'(cfg.long_press_ticks))) begin
            long_done_in = 1'b1;
            long_p       = 1'b1;
         end
      end

      result.short_press = short_p;
      result.long_press  = long_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff  <= 1'b1;
         deb_level_ff <= 1'b1;
         quiet_ff     <= '0;
         uptime_ff    <= '0;
         armed_ff     <= 1'b0;
         held_ff      <= '0;
         long_done_ff <= 1'b0;
      end else if (step) begin
         last_raw_ff  <= last_raw_in;
         deb_level_ff <= deb_level_in;
         quiet_ff     <= quiet_in;
         uptime_ff    <= uptime_in;
         armed_ff     <= armed_in;
         held_ff      <= held_in;
         long_done_ff <= long_done_in;
      end
   end

   assign stat.press_armed = armed_ff;
   assign stat.long_done   = long_done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/button_short_long_press.sv =====
// Top level of the debounced button with short and long press detection.
// Each request word is one tick: a raw active-low pin sample and a long-press
// inhibit bit. Every accepted word yields exactly one response word carrying a
// short_press and a long_press flag, at most one of them set. The sample is
// debounced (a level counts once it has stayed unchanged for more than
// debounce_ticks words), presses are armed only once the uptime exceeds
// boot_lockout_ticks, long_press pulses when the hold reaches long_press_ticks
// unless inhibited, and short_press pulses on release if no long press fired and
// the hold reached hold_min_ticks. All counters saturate at COUNT_WIDTH bits.
// Rate: one word per clock while responses drain. The whole counter update and
// compare sits between the state registers and a single response register, so a
// response appears in the cycle after its request is taken, and a new request is
// taken while the response register is empty or is being drained in the same
// cycle. The four timing registers are written through the csr channel (index
// 0 debounce, 1 minimum hold, 2 long press, 3 boot lockout; other indexes are
// dropped) and should only be changed while no word is in flight.
`default_nettype none
module button_short_long_press import bslp_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   bslp_req_if.sink   req_bus,
   bslp_rsp_if.source rsp_bus,
   bslp_csr_if.sink   csr_bus
);

   bslp_cfg_type  cfg_ff, cfg_in;
   bslp_in_type   item;
   bslp_out_type  result;
   bslp_stat_type stat;
   bslp_out_type  rsp_word_ff, rsp_word_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_ready;
   logic          accept;

   // Register writes: ready whenever out of reset, unknown indexes are dropped.
   assign csr_bus.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_DEBOUNCE: cfg_in.debounce_ticks     = csr_bus.data;
            REG_HOLD_MIN: cfg_in.hold_min_ticks     = csr_bus.data;
            REG_LONG:     cfg_in.long_press_ticks   = csr_bus.data;
            REG_LOCKOUT:  cfg_in.boot_lockout_ticks = csr_bus.data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.hold_min_ticks     <= HOLD_MIN_RST;
         cfg_ff.long_press_ticks   <= LONG_RST;
         cfg_ff.boot_lockout_ticks <= LOCKOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a request whenever the response register is free this cycle.
   assign req_ready     = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;

   assign item.raw_level    = req_bus.raw_level;
   assign item.long_inhibit = req_bus.long_inhibit;

   bslp_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result),
      .stat   (stat)
   );

   // Hold the response until taken; load a fresh one on every accept.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
   assign rsp_word_in  = accept ? result : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.short_press = rsp_word_ff.short_press;
   assign rsp_bus.long_press  = rsp_word_ff.long_press;

   // Checks on the detector's own behaviour.
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.short_press && rsp_word_ff.long_press))
      else $error("short and long press set in one response word");

   a_long_marks_done: assert property (@(posedge clock) disable iff (reset)
      (accept && result.long_press) |=> stat.long_done)
      else $error("long press fired without marking the press done");

   a_short_disarms: assert property (@(posedge clock) disable iff (reset)
      (accept && result.short_press) |=> !stat.press_armed)
      else $error("press still armed after short press release");

   a_free_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request refused while response register is empty");

endmodule
`default_nettype wire
